// ===== src/esd_pkg.sv =====
`default_nettype none
package esd_pkg;

  // Default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Per-transaction side information that travels with the data down the pipe
  typedef struct packed {
    logic dvd_neg;   // dividend was negative
    logic dvs_neg;   // divisor was negative
    logic dvs_zero;  // divisor was zero
  } esd_ctl_t;

endpackage
`default_nettype wire

// ===== src/esd_step.sv =====
`default_nettype none
// One restoring-division stage: resolves one quotient bit per transaction.
module esd_step #(
  parameter int unsigned DATA_WIDTH = esd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire esd_pkg::esd_ctl_t         in_ctl,
  input  wire logic [2*DATA_WIDTH-1:0]   in_rq,
  input  wire logic [DATA_WIDTH-1:0]     in_dvs,
  output logic                           out_valid,
  output esd_pkg::esd_ctl_t              out_ctl,
  output logic [2*DATA_WIDTH-1:0]        out_rq,
  output logic [DATA_WIDTH-1:0]          out_dvs
);

  localparam int unsigned W = DATA_WIDTH;

  logic                  valid_r;
  esd_pkg::esd_ctl_t     ctl_r;
  logic [2*W-1:0]        rq_r;
  logic [2*W-1:0]        rq_nxt;
  logic [W-1:0]          dvs_r;
  logic [W:0]            trial;
  logic [W:0]            diff;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {in_rq[2*W-1:W], in_rq[W-1]};
    diff  = trial - {1'b0, in_dvs};
    if (!diff[W]) begin
      rq_nxt = {diff[W-1:0], in_rq[W-2:0], 1'b1};
    end else begin
      rq_nxt = {trial[W-1:0], in_rq[W-2:0], 1'b0};
    end
  end

  // Advance the stage when the pipe moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= in_ctl;
      rq_r  <= rq_nxt;
      dvs_r <= in_dvs;
    end
  end

  assign out_valid = valid_r;
  assign out_ctl   = ctl_r;
  assign out_rq    = rq_r;
  assign out_dvs   = dvs_r;

endmodule
`default_nettype wire

// ===== src/esd_fixup.sv =====
`default_nettype none
// Euclidean correction, flags and sign restore over two register stages.
module esd_fixup #(
  parameter int unsigned DATA_WIDTH = esd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire esd_pkg::esd_ctl_t           in_ctl,
  input  wire logic [2*DATA_WIDTH-1:0]     in_rq,
  input  wire logic [DATA_WIDTH-1:0]       in_dvs,
  output logic                             out_valid,
  output logic signed [DATA_WIDTH-1:0]     out_quotient,
  output logic [DATA_WIDTH-2:0]            out_remainder,
  output logic                             out_divide_by_zero,
  output logic                             out_overflow
);

  localparam int unsigned W = DATA_WIDTH;

  // Correction stage
  logic          adj;
  logic [W-1:0]  qm;
  logic [W-1:0]  rm;
  logic [W-1:0]  qmag_nxt;
  logic [W-1:0]  rem_nxt;
  logic          qneg_nxt;
  logic          valid_a_r;
  logic [W-1:0]  qmag_r;
  logic [W-1:0]  rem_r;
  logic          qneg_r;
  logic          dbz_r;
  logic          ovf_r;

  // Output stage
  logic          valid_b_r;
  logic [W-1:0]  quo_nxt;
  logic [W-1:0]  quo_r;
  logic [W-2:0]  remo_r;
  logic          dbz_b_r;
  logic          ovf_b_r;

  // Step a negative dividend's result up so the remainder is non-negative
  always_comb begin
    qm       = in_rq[W-1:0];
    rm       = in_rq[2*W-1:W];
    adj      = in_ctl.dvd_neg && (rm != '0);
    qmag_nxt = adj ? qm + 1'b1 : qm;
    rem_nxt  = adj ? in_dvs - rm : rm;
    qneg_nxt = (in_ctl.dvd_neg != in_ctl.dvs_neg) && (qmag_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else if (en) begin
      valid_a_r <= in_valid;
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qmag_r <= qmag_nxt;
      rem_r  <= rem_nxt;
      qneg_r <= qneg_nxt;
      dbz_r  <= in_ctl.dvs_zero;
      // A positive quotient of the sign-bit weight does not fit
      ovf_r  <= !in_ctl.dvs_zero && !qneg_nxt && qmag_nxt[W-1];
    end
  end

  // Restore the sign and drop flagged results to zero
  always_comb begin
    if (dbz_r || ovf_r) begin
      quo_nxt = '0;
    end else if (qneg_r) begin
      quo_nxt = ~qmag_r + 1'b1;
    end else begin
      quo_nxt = qmag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r   <= quo_nxt;
      remo_r  <= (dbz_r || ovf_r) ? '0 : rem_r[W-2:0];
      dbz_b_r <= dbz_r;
      ovf_b_r <= ovf_r;
    end
  end

  assign out_valid          = valid_b_r;
  assign out_quotient       = quo_r;
  assign out_remainder      = remo_r;
  assign out_divide_by_zero = dbz_b_r;
  assign out_overflow       = ovf_b_r;

endmodule
`default_nettype wire

// ===== src/euclidean_signed_divider.sv =====
`default_nettype none
// Channel   Ports                                          Dir   Handshake
// input     in_dividend, in_divisor                        in    in_valid / in_ready
// result    out_quotient, out_remainder,                   out   out_valid / out_ready
//           out_divide_by_zero, out_overflow
//
// Takes one operand pair per cycle while the pipeline is not halted; it has
// one magnitude stage, DATA_WIDTH restoring-subtract stages (one quotient bit
// each), a correction stage and the output register.
// Reset clears the valid bits only; no clearing pass.
// While the output register holds a result that is not taken, the whole
// pipeline halts and in_ready is low; nothing is dropped or repeated.
module euclidean_signed_divider #(
  parameter int unsigned DATA_WIDTH = esd_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_dividend,
  input  wire logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_quotient,
  output logic [DATA_WIDTH-2:0]             out_remainder,
  output logic                              out_divide_by_zero,
  output logic                              out_overflow
);

  localparam int unsigned W = DATA_WIDTH;

  logic                  pipe_en;
  logic [W-1:0]          dvd_raw;
  logic [W-1:0]          dvs_raw;
  logic [W-1:0]          dvd_mag;
  logic [W-1:0]          dvs_mag;

  logic                  valid_r;
  esd_pkg::esd_ctl_t     ctl_r;
  logic [W-1:0]          dvd_r;
  logic [W-1:0]          dvs_r;

  logic                  valid_s [0:W];
  esd_pkg::esd_ctl_t     ctl_s   [0:W];
  logic [2*W-1:0]        rq_s    [0:W];
  logic [W-1:0]          dvs_s   [0:W];

  // Move the whole pipe unless a finished result is held
  assign pipe_en  = !out_valid || out_ready;
  assign in_ready = pipe_en;

  // Form magnitudes; W unsigned bits hold the most negative value exactly
  always_comb begin
    dvd_raw = in_dividend;
    dvs_raw = in_divisor;
    dvd_mag = dvd_raw[W-1] ? ~dvd_raw + 1'b1 : dvd_raw;
    dvs_mag = dvs_raw[W-1] ? ~dvs_raw + 1'b1 : dvs_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pipe_en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ctl_r.dvd_neg  <= dvd_raw[W-1];
      ctl_r.dvs_neg  <= dvs_raw[W-1];
      ctl_r.dvs_zero <= (dvs_raw == '0);
      dvd_r          <= dvd_mag;
      dvs_r          <= dvs_mag;
    end
  end

  assign valid_s[0] = valid_r;
  assign ctl_s[0]   = ctl_r;
  assign rq_s[0]    = {{W{1'b0}}, dvd_r};
  assign dvs_s[0]   = dvs_r;

  // Divider stages, most significant quotient bit first
  for (genvar g = 0; g < W; g++) begin : g_step
    esd_step #(
      .DATA_WIDTH (W)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (valid_s[g]),
      .in_ctl    (ctl_s[g]),
      .in_rq     (rq_s[g]),
      .in_dvs    (dvs_s[g]),
      .out_valid (valid_s[g+1]),
      .out_ctl   (ctl_s[g+1]),
      .out_rq    (rq_s[g+1]),
      .out_dvs   (dvs_s[g+1])
    );
  end

  esd_fixup #(
    .DATA_WIDTH (W)
  ) u_fixup (
    .clk                (clk),
    .rst_n              (rst_n),
    .en                 (pipe_en),
    .in_valid           (valid_s[W]),
    .in_ctl             (ctl_s[W]),
    .in_rq              (rq_s[W]),
    .in_dvs             (dvs_s[W]),
    .out_valid          (out_valid),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero),
    .out_overflow       (out_overflow)
  );

  // Flags exclude each other
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_divide_by_zero && out_overflow))
    else $error("divide_by_zero and overflow both set");

  // A flagged result carries zero quotient and remainder
  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_divide_by_zero || out_overflow)) |->
      (out_quotient == '0) && (out_remainder == '0))
    else $error("flagged result not zero");

  // A stalled pipe holds its first stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(valid_r) && $stable(dvd_r) && $stable(dvs_r))
    else $error("first stage moved during stall");

endmodule
`default_nettype wire

// ===== bench/esd_checker.sv =====
`timescale 1ns / 1ps
module esd_checker #(
  parameter int unsigned DW = esd_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [DW-1:0]     in_dividend,
  input  logic [DW-1:0]     in_divisor,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DW-1:0]     out_quotient,
  input  logic [DW-2:0]     out_remainder,
  input  logic              out_divide_by_zero,
  input  logic              out_overflow,
  output int unsigned       n_mismatch,
  output int unsigned       n_pending,
  output int unsigned       n_checked,
  output int unsigned       n_zero_div,
  output int unsigned       n_ovf,
  output int unsigned       n_neg_quot
);

  localparam int unsigned REPORT_MAX = 10;
  // 2^(DW-1) held one bit wider than the operands
  localparam logic [DW:0] SIGN_MAG = {2'b01, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [DW-1:0] quotient;
    logic [DW-2:0] remainder;
    logic          divide_by_zero;
    logic          overflow;
  } quot_rem_t;

  quot_rem_t quot_rem_due[$];

  // Euclidean quotient and remainder, magnitudes one bit wider than operands
  function automatic quot_rem_t euclid_divide(input logic [DW-1:0] dvd,
                                              input logic [DW-1:0] dvs);
    logic [DW:0] am, bm, qm, rm, qmag, rmag;
    logic        an, bn, qneg, fits;
    quot_rem_t   res;
    res = '0;
    an  = dvd[DW-1];
    bn  = dvs[DW-1];
    am  = an ? ({1'b0, ~dvd} + 1'b1) : {1'b0, dvd};
    bm  = bn ? ({1'b0, ~dvs} + 1'b1) : {1'b0, dvs};
    if (bm == '0) begin
      res.divide_by_zero = 1'b1;
      return res;
    end
    qm = am / bm;
    rm = am % bm;
    // a negative dividend with a remainder rounds the magnitude up
    if (an && rm != '0) begin
      qmag = qm + 1'b1;
      rmag = bm - rm;
    end else begin
      qmag = qm;
      rmag = rm;
    end
    qneg = (an != bn) && (qmag != '0);
    fits = qneg ? (qmag <= SIGN_MAG) : (qmag < SIGN_MAG);
    if (!fits) begin
      res.overflow = 1'b1;
      return res;
    end
    res.quotient  = qneg ? (~qmag[DW-1:0] + 1'b1) : qmag[DW-1:0];
    res.remainder = rmag[DW-2:0];
    return res;
  endfunction

  // Compare results first, then queue the new expectation
  always @(posedge clk) begin
    quot_rem_t exp_r, got_r;
    if (!rst_n) begin
      quot_rem_due.delete();
      n_mismatch <= 0;
      n_pending  <= 0;
      n_checked  <= 0;
      n_zero_div <= 0;
      n_ovf      <= 0;
      n_neg_quot <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got_r = '{out_quotient, out_remainder, out_divide_by_zero, out_overflow};
        if (quot_rem_due.size() == 0) begin
          if (n_mismatch < REPORT_MAX)
            $display("%0t: result with nothing outstanding: q=%0d r=%0d dbz=%b ovf=%b",
                     $time, $signed(got_r.quotient), got_r.remainder,
                     got_r.divide_by_zero, got_r.overflow);
          n_mismatch <= n_mismatch + 1;
        end else begin
          exp_r = quot_rem_due.pop_front();
          if (got_r.quotient !== exp_r.quotient || got_r.remainder !== exp_r.remainder ||
              got_r.divide_by_zero !== exp_r.divide_by_zero ||
              got_r.overflow !== exp_r.overflow) begin
            if (n_mismatch < REPORT_MAX)
              $display("%0t: mismatch exp q=%0d r=%0d dbz=%b ovf=%b, got q=%0d r=%0d dbz=%b ovf=%b",
                       $time, $signed(exp_r.quotient), exp_r.remainder,
                       exp_r.divide_by_zero, exp_r.overflow,
                       $signed(got_r.quotient), got_r.remainder,
                       got_r.divide_by_zero, got_r.overflow);
            n_mismatch <= n_mismatch + 1;
          end
          n_checked  <= n_checked + 1;
          n_zero_div <= n_zero_div + exp_r.divide_by_zero;
          n_ovf      <= n_ovf + exp_r.overflow;
          n_neg_quot <= n_neg_quot + exp_r.quotient[DW-1];
        end
      end
      if (in_valid && in_ready)
        quot_rem_due.push_back(euclid_divide(in_dividend, in_divisor));
      n_pending <= quot_rem_due.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned DW         = esd_pkg::DATA_WIDTH_DEF;
  localparam int unsigned N_RANDOM   = 1500;
  localparam int unsigned CALM_SPAN  = 250;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned LATENCY    = DW + 3;

  localparam logic [DW-1:0] S_MIN     = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] S_MAX     = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINUS_ONE = '1;

  logic          clk;
  logic          rst_n         = 1'b0;
  logic          in_valid      = 1'b0;
  logic [DW-1:0] in_dividend   = '0;
  logic [DW-1:0] in_divisor    = '0;
  logic          out_ready     = 1'b0;
  logic          in_ready;
  logic          out_valid;
  logic [DW-1:0] out_quotient;
  logic [DW-2:0] out_remainder;
  logic          out_divide_by_zero;
  logic          out_overflow;

  int unsigned   n_mismatch, n_pending, n_checked, n_zero_div, n_ovf, n_neg_quot;
  int unsigned   stall_left = 0;
  int unsigned   idle_cycles = 0;
  bit            calm = 1'b0;

  euclidean_signed_divider #(.DATA_WIDTH(DW)) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero),
    .out_overflow       (out_overflow)
  );

  esd_checker #(.DW(DW)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero),
    .out_overflow       (out_overflow),
    .n_mismatch         (n_mismatch),
    .n_pending          (n_pending),
    .n_checked          (n_checked),
    .n_zero_div         (n_zero_div),
    .n_ovf              (n_ovf),
    .n_neg_quot         (n_neg_quot)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: short stalls now and then, a rare long one, none while calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abort when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("no transaction for %0d cycles at %0t", IDLE_LIMIT, $time);
      $display("** euclidean_signed_divider: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned send_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (calm || sel < 55)
      return 0;
    if (sel < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DW-1:0] rand_operand();
    logic [DW-1:0] v;
    v = '0;
    case ($urandom_range(0, 7))
      3: v = $urandom_range(0, 64) - 32;
      4: begin
        v = $urandom >> $urandom_range(1, DW - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      5: begin
        case ($urandom_range(0, 5))
          0: v = S_MIN;
          1: v = S_MAX;
          2: v = S_MIN + 1'b1;
          3: v = S_MAX - 1'b1;
          4: v = MINUS_ONE;
          default: v = '0;
        endcase
      end
      6: begin
        v[$urandom_range(0, DW - 1)] = 1'b1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Present one operand pair, hold it until taken, then idle for a random gap, possibly none
  task automatic offer_pair(input logic [DW-1:0] dvd, input logic [DW-1:0] dvs);
    int unsigned gap;
    in_valid    <= 1'b1;
    in_dividend <= dvd;
    in_divisor  <= dvs;
    do @(posedge clk); while (!in_ready);
    gap = send_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding division has returned
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sel;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero divisor, overflow, sign combinations
    offer_pair('0, 1);
    offer_pair(S_MAX, 1);
    offer_pair(S_MIN, 1);
    offer_pair(S_MIN, MINUS_ONE);
    offer_pair(S_MAX, '0);
    offer_pair(S_MIN, '0);
    offer_pair('0, '0);
    offer_pair(-7, 2);
    offer_pair(7, -2);
    offer_pair(-7, -2);
    offer_pair(-6, 3);
    offer_pair(S_MIN, S_MAX);
    offer_pair(S_MAX, S_MIN);
    offer_pair(S_MIN, S_MIN);
    offer_pair(MINUS_ONE, S_MIN);
    offer_pair(MINUS_ONE, S_MAX);
    offer_pair(S_MIN, 2);
    offer_pair(S_MIN, -3);
    offer_pair(S_MAX, MINUS_ONE);
    offer_pair(S_MIN + 1'b1, MINUS_ONE);
    offer_pair(5, 7);
    offer_pair(-5, 7);
    drain_results();

    // Random: alternate busy spans with spans free of idling
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      calm = ((i / CALM_SPAN) % 2) == 1;
      if (i == N_RANDOM / 2)
        drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 3)
        offer_pair(rand_operand(), '0);
      else if (sel < 5)
        offer_pair(S_MIN, MINUS_ONE);
      else
        offer_pair(rand_operand(), rand_operand());
    end
    calm = 1'b0;
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);

    $display("Checked %0d divisions: %0d by zero, %0d overflowing, %0d with negative quotient.",
             n_checked, n_zero_div, n_ovf, n_neg_quot);
    $display("Random operands mixed full-range, small, corner and power-of-two values.");
    if (n_mismatch == 0 && n_pending == 0) begin
      $display("** euclidean_signed_divider: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_mismatch, n_pending);
      $display("** euclidean_signed_divider: FAILED **");
    end
    $finish;
  end

endmodule
